// File: hdl/ibt_pkg.sv
// Shared operation and status codes for the interval bitset table.
package ibt_pkg;

  // Operation selector carried with each input item.
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_SET       = 3'd0;
  localparam kind_t KIND_CLEAR     = 3'd1;
  localparam kind_t KIND_QUERY     = 3'd2;
  localparam kind_t KIND_APPEND    = 3'd3;
  localparam kind_t KIND_CLEAR_ALL = 3'd4;

  // Completion status carried with each result item.
  typedef logic [1:0] status_t;
  localparam status_t STAT_OK      = 2'd0;
  localparam status_t STAT_ORDER   = 2'd1;
  localparam status_t STAT_NOCLEAR = 2'd2;
  localparam status_t STAT_FULL    = 2'd3;

endpackage

// File: hdl/interval_bitset_table.sv
// Interval bitset table: a bitset held as ascending intervals in two memories.
// Flow: an accepted item is executed, then its result is loaded into the output register; a
//   query adds one bisection step per lower-bound read and an upper-bound read when a candidate is found.
// Only one item is in work at a time: s_tready stays low until its result is loaded, and a
//   finished result waits while the output register still holds an earlier one.
// Synchronous reset empties the table and clears the extent; memories keep their contents.
module interval_bitset_table import ibt_pkg::*; #(
  parameter int MAX_INTERVALS = 1024,
  parameter int INDEX_BITS    = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // Fields from bit 0 up: position, span_end, zero fill to whole bytes.
  input  logic [((2 * INDEX_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // Fields from bit 0 up: kind.
  input  logic [2:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // Fields from bit 0 up: bit_value, interval_count, extent, zero fill to whole bytes.
  output logic [((1 + $clog2(MAX_INTERVALS + 1) + INDEX_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata,
  // Fields from bit 0 up: status.
  output logic [1:0] m_tuser
);

  localparam int IB    = INDEX_BITS;
  localparam int EW    = INDEX_BITS + 1;
  localparam int CW    = $clog2(MAX_INTERVALS + 1);
  localparam int AW    = $clog2(MAX_INTERVALS);
  localparam int OUT_W = ((1 + CW + EW + 7) / 8) * 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_UPPER,
    S_DONE
  } state_t;

  // Interval storage.
  logic [IB-1:0] lower_mem [MAX_INTERVALS];
  logic [IB-1:0] upper_mem [MAX_INTERVALS];
  logic [IB-1:0] lower_rd;
  logic [IB-1:0] upper_rd;

  state_t        state, state_next;
  kind_t         op_kind;
  logic [IB-1:0] op_pos;
  logic [IB-1:0] op_end;
  logic [CW-1:0] count, count_next;
  logic [EW-1:0] extent, extent_next;
  logic [IB-1:0] last_lo, last_lo_next;
  logic [IB-1:0] last_hi, last_hi_next;
  logic [CW-1:0] srch_lo, srch_lo_next;
  logic [CW-1:0] srch_hi, srch_hi_next;
  logic [CW-1:0] srch_mid, srch_mid_next;
  logic          res_bit, res_bit_next;
  status_t       res_status, res_status_next;

  // Memory port controls.
  logic          wr_lo_en, wr_hi_en;
  logic [AW-1:0] wr_addr;
  logic [IB-1:0] wr_lo, wr_hi;
  logic          rd_lo_en, rd_hi_en;
  logic [AW-1:0] rd_addr;

  // Helpers for the last stored interval and the extent update.
  logic          have;
  logic          full;
  logic          out_free;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] lo_m1;
  logic [AW-1:0] last_addr;
  logic [AW-1:0] push_addr;
  logic [EW-1:0] pos_ext, end_ext, hi_p1;
  logic [EW-1:0] pos_touch, end_touch;

  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign have      = (count != '0);
  assign full      = (count == CW'(MAX_INTERVALS));
  assign cnt_m1    = count - CW'(1);
  assign last_addr = cnt_m1[AW-1:0];
  assign push_addr = count[AW-1:0];
  assign lo_m1     = srch_lo_next - CW'(1);
  assign pos_ext   = {1'b0, op_pos};
  assign end_ext   = {1'b0, op_end};
  assign hi_p1     = {1'b0, last_hi} + EW'(1);
  assign pos_touch = (pos_ext + EW'(1) > extent) ? pos_ext + EW'(1) : extent;
  assign end_touch = (end_ext + EW'(1) > extent) ? end_ext + EW'(1) : extent;

  // Operation decode, bisection steps and next-state logic.
  always_comb begin
    state_next      = state;
    count_next      = count;
    extent_next     = extent;
    last_lo_next    = last_lo;
    last_hi_next    = last_hi;
    srch_lo_next    = srch_lo;
    srch_hi_next    = srch_hi;
    srch_mid_next   = srch_mid;
    res_bit_next    = res_bit;
    res_status_next = res_status;
    wr_lo_en        = 1'b0;
    wr_hi_en        = 1'b0;
    wr_addr         = last_addr;
    wr_lo           = op_pos;
    wr_hi           = op_pos;
    rd_lo_en        = 1'b0;
    rd_hi_en        = 1'b0;
    rd_addr         = '0;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        res_bit_next    = 1'b0;
        res_status_next = STAT_OK;
        state_next      = S_DONE;
        unique case (op_kind)
          KIND_SET: begin
            priority if (have && last_lo > op_pos) begin
              res_status_next = STAT_ORDER;
            end else if (have && op_pos <= last_hi) begin
              // Bit already lies inside the last interval.
              extent_next = pos_touch;
            end else if (have && pos_ext == hi_p1) begin
              last_hi_next = op_pos;
              wr_hi_en     = 1'b1;
              extent_next  = pos_touch;
            end else if (full) begin
              res_status_next = STAT_FULL;
            end else begin
              wr_lo_en     = 1'b1;
              wr_hi_en     = 1'b1;
              wr_addr      = push_addr;
              last_lo_next = op_pos;
              last_hi_next = op_pos;
              count_next   = count + CW'(1);
              extent_next  = pos_touch;
            end
          end
          KIND_CLEAR: begin
            if (!have || last_hi < op_pos) begin
              extent_next = pos_touch;
            end else begin
              res_status_next = STAT_NOCLEAR;
            end
          end
          KIND_QUERY: begin
            if (have) begin
              srch_lo_next  = '0;
              srch_hi_next  = count;
              srch_mid_next = count >> 1;
              rd_lo_en      = 1'b1;
              rd_addr       = srch_mid_next[AW-1:0];
              state_next    = S_SEARCH;
            end
          end
          KIND_APPEND: begin
            priority if (op_pos > op_end) begin
              res_status_next = STAT_ORDER;
            end else if (have && op_end < last_hi) begin
              res_status_next = STAT_ORDER;
            end else if (have && pos_ext <= hi_p1) begin
              // Overlapping or adjacent: merge into the last interval.
              last_hi_next = op_end;
              wr_hi_en     = 1'b1;
              wr_hi        = op_end;
              extent_next  = end_touch;
            end else if (full) begin
              res_status_next = STAT_FULL;
            end else begin
              wr_lo_en     = 1'b1;
              wr_hi_en     = 1'b1;
              wr_addr      = push_addr;
              wr_hi        = op_end;
              last_lo_next = op_pos;
              last_hi_next = op_end;
              count_next   = count + CW'(1);
              extent_next  = end_touch;
            end
          end
          KIND_CLEAR_ALL: begin
            count_next  = '0;
            extent_next = '0;
          end
          default: begin
          end
        endcase
      end

      S_SEARCH: begin
        // The lower bound at srch_mid has arrived; narrow the window.
        if (lower_rd <= op_pos) begin
          srch_lo_next = srch_mid + CW'(1);
        end else begin
          srch_hi_next = srch_mid;
        end
        priority if (srch_lo_next < srch_hi_next) begin
          srch_mid_next = srch_lo_next + ((srch_hi_next - srch_lo_next) >> 1);
          rd_lo_en      = 1'b1;
          rd_addr       = srch_mid_next[AW-1:0];
        end else if (srch_lo_next == '0) begin
          res_bit_next = 1'b0;
          state_next   = S_DONE;
        end else begin
          rd_hi_en   = 1'b1;
          rd_addr    = lo_m1[AW-1:0];
          state_next = S_UPPER;
        end
      end

      S_UPPER: begin
        res_bit_next = (op_pos <= upper_rd);
        state_next   = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, table control and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      extent   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      extent <= extent_next;
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (s_tvalid && s_tready) begin
      op_kind <= s_tuser;
      op_pos  <= s_tdata[IB-1:0];
      op_end  <= s_tdata[2*IB-1:IB];
    end
    last_lo    <= last_lo_next;
    last_hi    <= last_hi_next;
    srch_lo    <= srch_lo_next;
    srch_hi    <= srch_hi_next;
    srch_mid   <= srch_mid_next;
    res_bit    <= res_bit_next;
    res_status <= res_status_next;
    if (state == S_DONE && out_free) begin
      m_tdata <= OUT_W'({extent, count, res_bit});
      m_tuser <= res_status;
    end
  end

  // Bound memories with one write and one registered read each.
  always_ff @(posedge clk) begin
    if (wr_lo_en) begin
      lower_mem[wr_addr] <= wr_lo;
    end
    if (wr_hi_en) begin
      upper_mem[wr_addr] <= wr_hi;
    end
    if (rd_lo_en) begin
      lower_rd <= lower_mem[rd_addr];
    end
    if (rd_hi_en) begin
      upper_rd <= upper_mem[rd_addr];
    end
  end

endmodule

// File: hdl/ibt_checker.sv
// Port-level checks for the interval bitset table, bound to the top level.
module ibt_checker import ibt_pkg::*; #(
  parameter int MAX_INTERVALS = 1024,
  parameter int INDEX_BITS    = 24
) (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  // Fields from bit 0 up: position, span_end, zero fill to whole bytes.
  input logic [((2 * INDEX_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // Fields from bit 0 up: kind.
  input logic [2:0] s_tuser,
  input logic m_tvalid,
  input logic m_tready,
  // Fields from bit 0 up: bit_value, interval_count, extent, zero fill to whole bytes.
  input logic [((1 + $clog2(MAX_INTERVALS + 1) + INDEX_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata,
  // Fields from bit 0 up: status.
  input logic [1:0] m_tuser
);

  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int EW = INDEX_BITS + 1;

  logic          out_bit;
  logic [CW-1:0] out_count;
  logic [EW-1:0] out_extent;

  assign out_bit    = m_tdata[0];
  assign out_count  = m_tdata[CW:1];
  assign out_extent = m_tdata[CW+EW:CW+1];

  // A full table is only reported when every entry is in use.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == STAT_FULL) |-> out_count == CW'(MAX_INTERVALS))
    else $error("table full reported below capacity");

  // A set bit comes only with an OK status.
  a_bit_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_bit) |-> m_tuser == STAT_OK)
    else $error("bit value set with an error status");

  // Stored intervals always raise the extent above zero.
  a_extent_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_extent == '0) |-> out_count == '0)
    else $error("intervals stored with zero extent");

  // A result that is not taken holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

endmodule

bind interval_bitset_table ibt_checker #(
  .MAX_INTERVALS(MAX_INTERVALS),
  .INDEX_BITS   (INDEX_BITS)
) u_ibt_checker (.*);

// File: bench/testbench.sv
// Self-checking testbench for the interval bitset table, with a directed table and random traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ibt_pkg::*;

  localparam int MAX_IV  = 1024;
  localparam int IDX_W   = 24;
  localparam int CNT_W   = $clog2(MAX_IV + 1);
  localparam int IN_W    = ((2 * IDX_W + 7) / 8) * 8;
  localparam int OUT_W   = ((1 + CNT_W + IDX_W + 1 + 7) / 8) * 8;
  localparam int N_DIRECTED = 26;

  // Kinds that the block treats as no operation.
  localparam kind_t KIND_UNUSED_LO = 3'd5;
  localparam kind_t KIND_UNUSED_HI = 3'd7;

  typedef logic [IDX_W-1:0] index_t;

  typedef struct packed {
    kind_t  op;
    index_t pos;
    index_t span;
  } bitset_op_t;

  typedef struct packed {
    logic             bit_value;
    status_t          status;
    logic [CNT_W-1:0] interval_count;
    logic [IDX_W:0]   extent;
  } bitset_result_t;

  // One directed row; the result fields count only where typed is set.
  typedef struct packed {
    kind_t            op;
    index_t           pos;
    index_t           span;
    bit               typed;
    logic             bit_value;
    status_t          status;
    logic [CNT_W-1:0] interval_count;
    logic [IDX_W:0]   extent;
  } stim_row_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic [2:0]       s_tuser = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [1:0]       m_tuser;

  // Mirror of the interval table, kept in step with accepted items.
  int unsigned iv_lo [MAX_IV];
  int unsigned iv_hi [MAX_IV];
  int unsigned iv_count = 0;
  int unsigned iv_extent = 0;

  bitset_result_t pending_results[$];
  bitset_result_t oldest;
  int             error_count = 0;
  int             sender_pct = 0;
  int             receiver_pct = 0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{KIND_QUERY,     24'd0,       24'd0,       1'b1, 1'b0, STAT_OK,      11'd0, 25'd0},
    '{KIND_CLEAR,     24'd5,       24'd0,       1'b1, 1'b0, STAT_OK,      11'd0, 25'd6},
    '{KIND_SET,       24'd10,      24'd0,       1'b1, 1'b0, STAT_OK,      11'd1, 25'd11},
    '{KIND_SET,       24'd11,      24'd0,       1'b1, 1'b0, STAT_OK,      11'd1, 25'd12},
    '{KIND_SET,       24'd10,      24'd0,       1'b1, 1'b0, STAT_OK,      11'd1, 25'd12},
    '{KIND_SET,       24'd3,       24'd0,       1'b1, 1'b0, STAT_ORDER,   11'd1, 25'd12},
    '{KIND_CLEAR,     24'd11,      24'd0,       1'b1, 1'b0, STAT_NOCLEAR, 11'd1, 25'd12},
    '{KIND_CLEAR,     24'd2,       24'd0,       1'b1, 1'b0, STAT_NOCLEAR, 11'd1, 25'd12},
    '{KIND_CLEAR,     24'd100,     24'd0,       1'b1, 1'b0, STAT_OK,      11'd1, 25'd101},
    '{KIND_SET,       24'd50,      24'd0,       1'b1, 1'b0, STAT_OK,      11'd2, 25'd101},
    '{KIND_APPEND,    24'd20,      24'd60,      1'b1, 1'b0, STAT_OK,      11'd2, 25'd101},
    '{KIND_APPEND,    24'd70,      24'd65,      1'b1, 1'b0, STAT_ORDER,   11'd2, 25'd101},
    '{KIND_APPEND,    24'd40,      24'd59,      1'b1, 1'b0, STAT_ORDER,   11'd2, 25'd101},
    '{KIND_APPEND,    24'd61,      24'd70,      1'b1, 1'b0, STAT_OK,      11'd2, 25'd101},
    '{KIND_APPEND,    24'd200,     24'd300,     1'b1, 1'b0, STAT_OK,      11'd3, 25'd301},
    '{KIND_QUERY,     24'd55,      24'd0,       1'b0, 1'b0, STAT_OK,      11'd0, 25'd0},
    '{KIND_QUERY,     24'd71,      24'd0,       1'b0, 1'b0, STAT_OK,      11'd0, 25'd0},
    '{KIND_QUERY,     24'd300,     24'd0,       1'b0, 1'b0, STAT_OK,      11'd0, 25'd0},
    '{KIND_UNUSED_LO, 24'hFFFFFF,  24'hFFFFFF,  1'b1, 1'b0, STAT_OK,      11'd3, 25'd301},
    '{KIND_UNUSED_HI, 24'h000000,  24'hFFFFFF,  1'b1, 1'b0, STAT_OK,      11'd3, 25'd301},
    '{KIND_APPEND,    24'h100000,  24'hFFFFFF,  1'b1, 1'b0, STAT_OK,      11'd4, 25'h1000000},
    '{KIND_SET,       24'hFFFFFF,  24'd0,       1'b1, 1'b0, STAT_OK,      11'd4, 25'h1000000},
    '{KIND_QUERY,     24'hFFFFFF,  24'd0,       1'b1, 1'b1, STAT_OK,      11'd4, 25'h1000000},
    '{KIND_CLEAR_ALL, 24'd0,       24'd0,       1'b1, 1'b0, STAT_OK,      11'd0, 25'd0},
    '{KIND_APPEND,    24'h000000,  24'hFFFFFF,  1'b1, 1'b0, STAT_OK,      11'd1, 25'h1000000},
    '{KIND_CLEAR_ALL, 24'd0,       24'd0,       1'b1, 1'b0, STAT_OK,      11'd0, 25'd0}
  };

  interval_bitset_table #(
    .MAX_INTERVALS(MAX_IV),
    .INDEX_BITS   (IDX_W)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Global watchdog.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // The extent only grows, to one past the highest bit touched.
  function automatic void raise_extent(int unsigned bit_index);
    if (bit_index + 1 > iv_extent) iv_extent = bit_index + 1;
  endfunction

  function automatic bit open_interval(int unsigned lo, int unsigned hi);
    if (iv_count >= MAX_IV) return 1'b0;
    iv_lo[iv_count] = lo;
    iv_hi[iv_count] = hi;
    iv_count++;
    return 1'b1;
  endfunction

  // Applies one operation to the mirror and returns the result it must produce.
  function automatic bitset_result_t apply_op(bitset_op_t t);
    bitset_result_t r;
    int unsigned p, e, lo_i, hi_i, mid;
    p = 32'(t.pos);
    e = 32'(t.span);
    r = '0;
    r.status = STAT_OK;
    case (t.op)
      KIND_SET: begin
        if (iv_count > 0 && iv_lo[iv_count-1] > p) begin
          r.status = STAT_ORDER;
        end else if (iv_count > 0 && p <= iv_hi[iv_count-1]) begin
          raise_extent(p);
        end else if (iv_count > 0 && p == iv_hi[iv_count-1] + 1) begin
          iv_hi[iv_count-1] = p;
          raise_extent(p);
        end else if (open_interval(p, p)) begin
          raise_extent(p);
        end else begin
          r.status = STAT_FULL;
        end
      end
      KIND_CLEAR: begin
        // Clearing works only past the last stored interval.
        if (iv_count == 0 || iv_hi[iv_count-1] < p) raise_extent(p);
        else r.status = STAT_NOCLEAR;
      end
      KIND_QUERY: begin
        lo_i = 0;
        hi_i = iv_count;
        while (lo_i < hi_i) begin
          mid = lo_i + ((hi_i - lo_i) >> 1);
          if (iv_lo[mid] <= p) lo_i = mid + 1;
          else hi_i = mid;
        end
        r.bit_value = (lo_i != 0) && (p <= iv_hi[lo_i-1]);
      end
      KIND_APPEND: begin
        if (p > e) begin
          r.status = STAT_ORDER;
        end else if (iv_count > 0 && e < iv_hi[iv_count-1]) begin
          r.status = STAT_ORDER;
        end else if (iv_count > 0 && p <= iv_hi[iv_count-1] + 1) begin
          iv_hi[iv_count-1] = e;
          raise_extent(e);
        end else if (open_interval(p, e)) begin
          raise_extent(e);
        end else begin
          r.status = STAT_FULL;
        end
      end
      KIND_CLEAR_ALL: begin
        iv_count = 0;
        iv_extent = 0;
      end
      default: ;
    endcase
    r.interval_count = iv_count[CNT_W-1:0];
    r.extent = iv_extent[IDX_W:0];
    return r;
  endfunction

  function automatic int unsigned last_upper();
    return (iv_count > 0) ? iv_hi[iv_count-1] : 0;
  endfunction

  // An item that opens a new interval just past the last one.
  function automatic bitset_op_t fresh_interval_op();
    bitset_op_t t;
    int unsigned lo;
    lo = last_upper() + $urandom_range(2, 17);
    t.pos = index_t'(lo);
    t.span = index_t'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      t.op = KIND_SET;
    end else begin
      t.op = KIND_APPEND;
      t.span = index_t'(lo + $urandom_range(0, 7));
    end
    return t;
  endfunction

  // Mostly ascending traffic from the last interval, with queries, noise and resets.
  function automatic bitset_op_t pick_random_op();
    bitset_op_t t;
    int unsigned top, cur_lo, r, lo;
    top = last_upper();
    cur_lo = (iv_count > 0) ? iv_lo[iv_count-1] : 0;
    r = $urandom_range(0, 99);
    t.pos = index_t'($urandom);
    t.span = index_t'($urandom);
    if (r < 12) begin
      t.op = KIND_SET;
      t.pos = index_t'(top + 1 + ((r < 6) ? 0 : $urandom_range(1, 40)));
    end else if (r < 20) begin
      // Bit already inside the last interval.
      t.op = KIND_SET;
      t.pos = index_t'($urandom_range(cur_lo, top));
    end else if (r < 35) begin
      t.op = KIND_APPEND;
      lo = ((top >= 4) ? top - 4 : 0) + $urandom_range(0, 48);
      t.pos = index_t'(lo);
      t.span = index_t'(lo + $urandom_range(0, 64));
    end else if (r < 55) begin
      t.op = KIND_QUERY;
      t.pos = index_t'($urandom_range(0, iv_extent + 16));
    end else if (r < 60) begin
      t.op = KIND_QUERY;
    end else if (r < 66) begin
      t.op = KIND_CLEAR;
      t.pos = index_t'(top + $urandom_range(1, 32));
    end else if (r < 70) begin
      t.op = KIND_CLEAR;
      t.pos = index_t'($urandom_range(0, top));
    end else if (r < 88) begin
      // Noise: any position, any bound, often out of order.
      case ($urandom_range(0, 2))
        0:       t.op = KIND_SET;
        1:       t.op = KIND_CLEAR;
        default: t.op = KIND_APPEND;
      endcase
      if ($urandom_range(0, 1) == 0) t.span = index_t'($urandom_range(0, top));
    end else if (r < 95) begin
      t.op = kind_t'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    end else begin
      t.op = KIND_CLEAR_ALL;
    end
    return t;
  endfunction

  // Idle modes: 0 none, 1 sender gaps, 2 receiver stalls, 3 both.
  task automatic set_idle_mode(int mode);
    sender_pct   = (mode == 1) ? 51 : (mode == 3) ? 32 : 0;
    receiver_pct = (mode == 2) ? 51 : (mode == 3) ? 32 : 0;
  endtask

  // Drives one item at the falling edge and records its result once it is taken.
  task automatic send_op(bitset_op_t t, bit typed, bitset_result_t want);
    bitset_result_t predicted;
    while (sender_pct != 0 && $urandom_range(0, 99) < sender_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= t.op;
    s_tdata  <= {t.span, t.pos};
    do @(posedge clk); while (!s_tready);
    predicted = apply_op(t);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Receiver side: random backpressure per the current mode.
  always @(negedge clk) begin
    m_tready <= !(receiver_pct != 0 && $urandom_range(0, 99) < receiver_pct);
  end

  // Compare every taken result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no expectation waiting");
        error_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (m_tdata[0] !== oldest.bit_value) begin
          $error("bit_value: expected %0d, got %0d", oldest.bit_value, m_tdata[0]);
          error_count++;
        end
        if (m_tuser !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, m_tuser);
          error_count++;
        end
        if (m_tdata[CNT_W:1] !== oldest.interval_count) begin
          $error("interval_count: expected %0d, got %0d", oldest.interval_count,
                 m_tdata[CNT_W:1]);
          error_count++;
        end
        if (m_tdata[CNT_W+IDX_W+1:CNT_W+1] !== oldest.extent) begin
          $error("extent: expected %0h, got %0h", oldest.extent,
                 m_tdata[CNT_W+IDX_W+1:CNT_W+1]);
          error_count++;
        end
      end
    end
  end

  // Stimulus sequence.
  initial begin
    bitset_op_t     t;
    bitset_result_t want;
    int             n;
    set_idle_mode(0);
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows.
    for (int i = 0; i < N_DIRECTED; i++) begin
      t.op   = directed_rows[i].op;
      t.pos  = directed_rows[i].pos;
      t.span = directed_rows[i].span;
      want.bit_value      = directed_rows[i].bit_value;
      want.status         = directed_rows[i].status;
      want.interval_count = directed_rows[i].interval_count;
      want.extent         = directed_rows[i].extent;
      send_op(t, directed_rows[i].typed, want);
    end

    // Random traffic under each idle mode; the sender holds off until all results are in.
    for (int mode = 0; mode < 4; mode++) begin
      set_idle_mode(mode);
      for (int i = 0; i < 60; i++) send_op(pick_random_op(), 1'b0, '0);
      s_tvalid <= 1'b0;
      wait_results_drained();
      @(negedge clk);
    end

    // Fill the table to capacity, with queries mixed in, rotating idle modes.
    set_idle_mode(0);
    t = '0;
    t.op = KIND_CLEAR_ALL;
    send_op(t, 1'b0, '0);
    n = 0;
    while (iv_count < MAX_IV) begin
      set_idle_mode((n / 300) % 4);
      if ($urandom_range(0, 99) < 8) begin
        t.op = KIND_QUERY;
        t.pos = index_t'($urandom_range(0, iv_extent));
        t.span = index_t'($urandom);
      end else begin
        t = fresh_interval_op();
      end
      send_op(t, 1'b0, '0);
      n++;
    end

    // Operations on a full table: new intervals are refused, merges still work.
    for (int k = 0; k < 12; k++) begin
      t.span = index_t'($urandom);
      case (k % 6)
        0, 1: t = fresh_interval_op();
        2: begin
          t.op = KIND_SET;
          t.pos = index_t'($urandom_range(iv_lo[iv_count-1], last_upper()));
        end
        3: begin
          t.op = KIND_APPEND;
          t.pos = index_t'(last_upper() + 1);
          t.span = index_t'(last_upper() + 3);
        end
        4: begin
          t.op = KIND_QUERY;
          t.pos = index_t'($urandom_range(0, iv_extent));
        end
        default: begin
          t.op = KIND_CLEAR;
          t.pos = (k < 6) ? index_t'(last_upper() + 5) : index_t'($urandom_range(0, last_upper()));
        end
      endcase
      send_op(t, 1'b0, '0);
    end
    t.op = KIND_CLEAR_ALL;
    send_op(t, 1'b0, '0);

    s_tvalid <= 1'b0;
    wait_results_drained();
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/ibt_pkg.sv
hdl/interval_bitset_table.sv
hdl/ibt_checker.sv
bench/testbench.sv
